// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mexp_pkg.sv =====
// package with controller states, command and status types and constants
package mexp_pkg;

  localparam int MOD_RESET = 391;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED_BASE,
    ST_BIT,
    ST_MUL_A,
    ST_RED_A,
    ST_NEXT,
    ST_MUL_S,
    ST_RED_S,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_acc;
    logic mul_acc;
    logic mul_sq;
    logic step;
    logic dest_sq;
    logic shift_exp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic exp_last;
    logic mod_small;
    logic div_last;
  } status_t;

endpackage

// ===== design/mexp_dp.sv =====
// datapath: operand registers, multiplier, bit-serial remainder unit, result register
module mexp_dp #(
  parameter int WIDTH = 16
) (
  input  logic                 clk,
  input  logic [WIDTH-1:0]     base,
  input  logic [WIDTH-1:0]     exponent,
  input  logic [WIDTH-1:0]     modulus,
  input  mexp_pkg::cmd_t       cmd,
  output mexp_pkg::status_t    status,
  output logic [WIDTH-1:0]     result
);
  import mexp_pkg::*;

  localparam int PW    = 2 * WIDTH;
  localparam int CNT_W = $clog2(PW);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] sq;
  logic [WIDTH-1:0] expo;
  logic [WIDTH-1:0] m;
  logic [PW-1:0]    prod;
  logic [WIDTH-1:0] rem;
  logic [CNT_W-1:0] cnt;

  logic [WIDTH-1:0] mul_a;
  logic [PW-1:0]    prod_next;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   m_ext;
  logic [WIDTH:0]   rem_next;
  logic             div_last;

  assign mul_a     = cmd.mul_acc ? acc : sq;
  assign prod_next = {{WIDTH{1'b0}}, mul_a} * {{WIDTH{1'b0}}, sq};

  assign rem_sh   = {rem, prod[PW-1]};
  assign m_ext    = {1'b0, m};
  assign rem_next = (rem_sh >= m_ext) ? (rem_sh - m_ext) : rem_sh;
  assign div_last = (cnt == CNT_W'(PW - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      expo <= exponent;
      m    <= modulus;
      prod <= {{WIDTH{1'b0}}, base};
      acc  <= WIDTH'(1);
      rem  <= '0;
      cnt  <= '0;
    end else begin
      if (cmd.clr_acc) begin
        acc <= '0;
      end
      if (cmd.mul_acc || cmd.mul_sq) begin
        prod <= prod_next;
        rem  <= '0;
        cnt  <= '0;
      end
      if (cmd.step) begin
        prod <= {prod[PW-2:0], 1'b0};
        rem  <= rem_next[WIDTH-1:0];
        cnt  <= cnt + CNT_W'(1);
        if (div_last) begin
          if (cmd.dest_sq) begin
            sq <= rem_next[WIDTH-1:0];
          end else begin
            acc <= rem_next[WIDTH-1:0];
          end
        end
      end
      if (cmd.shift_exp) begin
        expo <= expo >> 1;
      end
    end
    if (cmd.out_load) begin
      result <= acc;
    end
  end

  assign status.exp_zero  = (expo == '0);
  assign status.exp_lsb   = expo[0];
  assign status.exp_last  = (expo[WIDTH-1:1] == '0);
  assign status.mod_small = (m[WIDTH-1:1] == '0);
  assign status.div_last  = div_last;

endmodule

// ===== design/mexp_ctrl.sv =====
// controller state machine sequencing square-and-multiply
module mexp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  mexp_pkg::status_t  status,
  output mexp_pkg::cmd_t     cmd
);
  import mexp_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.exp_zero || status.mod_small) state_next = ST_DONE;
        else state_next = ST_RED_BASE;
      end
      ST_RED_BASE: begin
        if (status.div_last) state_next = ST_BIT;
      end
      ST_BIT: begin
        if (status.exp_lsb) state_next = ST_MUL_A;
        else state_next = ST_NEXT;
      end
      ST_MUL_A: state_next = ST_RED_A;
      ST_RED_A: begin
        if (status.div_last) state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (status.exp_last) state_next = ST_DONE;
        else state_next = ST_MUL_S;
      end
      ST_MUL_S: state_next = ST_RED_S;
      ST_RED_S: begin
        if (status.div_last) state_next = ST_BIT;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_CHECK: cmd.clr_acc = !status.exp_zero && status.mod_small;
      ST_RED_BASE: begin
        cmd.step    = 1'b1;
        cmd.dest_sq = 1'b1;
      end
      ST_BIT: ;
      ST_MUL_A: cmd.mul_acc = 1'b1;
      ST_RED_A: cmd.step = 1'b1;
      ST_NEXT: cmd.shift_exp = 1'b1;
      ST_MUL_S: cmd.mul_sq = 1'b1;
      ST_RED_S: begin
        cmd.step    = 1'b1;
        cmd.dest_sq = 1'b1;
      end
      ST_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/modular_exponentiation.sv =====
// top level: modular exponentiation with configurable modulus
//
// Computes base ** exponent mod modulus by right-to-left square-and-multiply.
// A request carries base and exponent; one result follows per request. An
// exponent of zero gives 1; a modulus below 2 gives 0 otherwise. Each modular
// multiply is one registered WIDTH x WIDTH product followed by a bit-serial
// remainder unit, and this unit sets the latency. One request is in flight at
// a time; the next is accepted while the previous result waits in the output
// register. The modulus register resets to 391 and is written through cfg_*;
// the user must write it only while the block is idle. The block itself does
// not enforce this.
module modular_exponentiation #(
  parameter int WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((2*WIDTH+7)/8)*8-1:0]      s_tdata,   // base, exponent
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [((WIDTH+7)/8)*8-1:0]        m_tdata,   // power_mod
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [WIDTH-1:0]                  cfg_data   // modulus
);
  import mexp_pkg::*;

  `include "assert_macros.svh"

  localparam int OUT_TW = ((WIDTH + 7) / 8) * 8;

  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] result;
  cmd_t             cmd;
  status_t          status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(MOD_RESET);
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk      (clk),
    .base     (s_tdata[WIDTH-1:0]),
    .exponent (s_tdata[2*WIDTH-1:WIDTH]),
    .modulus  (modulus),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

  assign m_tdata = OUT_TW'(result);

  `ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready, "request taken while busy")
  `ASSERT_IMPL(a_idle_on_result, $rose(m_tvalid), s_tready, "result shown while still busy")

endmodule

// ===== tb/sv/tb_modular_exponentiation.sv =====
// testbench for modular_exponentiation: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module tb_modular_exponentiation;

  localparam int WIDTH          = 16;
  localparam int MOD_AT_RESET   = 391;
  localparam int MOD_MAX        = 65535;
  localparam int CYCLE_LIMIT    = 6_000_000;
  localparam int SETTLE_CYCLES  = 1200;
  localparam int HOLD_OFF       = 4000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_REQUESTS = 155;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata = '0;   // base, exponent
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [15:0]      m_tdata;        // power_mod
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [WIDTH-1:0] cfg_data = '0;  // modulus

  logic [WIDTH-1:0] modulus_now = WIDTH'(MOD_AT_RESET);
  logic [WIDTH-1:0] expected_power_mod[$];
  int               error_count = 0;
  int               requests_sent = 0;
  int               results_checked = 0;
  int               moduli_written = 0;
  int               burst_left = 0;
  int               hold_cycles = 0;
  int               stall_mode = 0;
  int               stall_tick = 0;
  longint           cycle_count = 0;

  modular_exponentiation #(
    .WIDTH(WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_power_mod.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // right-to-left square-and-multiply at double width
  function automatic logic [WIDTH-1:0] predict_power_mod(logic [WIDTH-1:0] base,
                                                         logic [WIDTH-1:0] exponent,
                                                         logic [WIDTH-1:0] modulus);
    logic [2*WIDTH-1:0] acc;
    logic [2*WIDTH-1:0] sq;
    logic [2*WIDTH-1:0] m;
    logic [WIDTH-1:0]   rest;
    if (exponent == '0) return WIDTH'(1);
    if (modulus < WIDTH'(2)) return '0;
    m    = {{WIDTH{1'b0}}, modulus};
    acc  = 1;
    sq   = {{WIDTH{1'b0}}, base} % m;
    rest = exponent;
    while (rest != '0) begin
      if (rest[0]) acc = (acc * sq) % m;
      rest = rest >> 1;
      if (rest != '0) sq = (sq * sq) % m;
    end
    return acc[WIDTH-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [WIDTH-1:0] got, logic [WIDTH-1:0] want);
    $display("mismatch at cycle %0d: %s got 0x%04h expected 0x%04h",
             cycle_count, what, got, want);
    error_count++;
  endtask

  // receiver: rotating stall pattern plus an optional long hold-off
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 200 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready    <= 1'b0;
    end else begin
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= (stall_tick % 4) != 3;
        2: m_tready <= $urandom_range(0, 1);
        default: m_tready <= (stall_tick % 16) >= 11;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_power_mod.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[WIDTH-1:0], '0);
      end else begin
        if (m_tdata[WIDTH-1:0] !== expected_power_mod[0])
          report_mismatch("power_mod", m_tdata[WIDTH-1:0], expected_power_mod[0]);
        void'(expected_power_mod.pop_front());
        results_checked++;
      end
    end
  end

  task automatic send_request(logic [WIDTH-1:0] base, logic [WIDTH-1:0] exponent);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {exponent, base};
    do @(posedge clk); while (!s_tready);
    expected_power_mod.push_back(predict_power_mod(base, exponent, modulus_now));
    requests_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (expected_power_mod.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_modulus(logic [WIDTH-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    modulus_now = value;
    moduli_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_request();
    logic [WIDTH-1:0] base;
    logic [WIDTH-1:0] exponent;
    int               nbits;
    case ($urandom_range(0, 7))
      0:       base = modulus_now + WIDTH'($urandom_range(0, 3));
      1:       base = ($urandom_range(0, 1) == 1) ? '1 : '0;
      default: base = WIDTH'($urandom());
    endcase
    case ($urandom_range(0, 3))
      0: exponent = WIDTH'($urandom());
      1: exponent = WIDTH'($urandom_range(0, 255));
      default: begin
        nbits    = $urandom_range(1, WIDTH);
        exponent = WIDTH'($urandom()) & WIDTH'((32'h1 << nbits) - 1);
      end
    endcase
    send_request(base, exponent);
  endtask

  task automatic test_reset_modulus();
    send_request(16'd0, 16'd0);
    send_request(16'hffff, 16'd0);
    send_request(16'd0, 16'd1);
    send_request(16'd1, 16'd1);
    send_request(16'd390, 16'd1);
    send_request(16'd391, 16'd1);
    send_request(16'd392, 16'd2);
    send_request(16'd2, 16'hffff);
    send_request(16'hffff, 16'hffff);
    send_request(16'd12345, 16'h8000);
    send_request(16'h5555, 16'haaaa);
  endtask

  task automatic test_modulus_extremes();
    set_modulus(WIDTH'(MOD_MAX));
    send_request(16'hfffe, 16'd2);
    send_request(16'hffff, 16'd3);
    send_request(16'haaaa, 16'hffff);
    set_modulus(WIDTH'(2));
    send_request(16'd3, 16'd5);
    send_request(16'd4, 16'd7);
  endtask

  // modulus below two: zero exponent still gives one
  task automatic test_degenerate_modulus();
    set_modulus(WIDTH'(1));
    send_request(16'd5, 16'd0);
    send_request(16'd5, 16'd7);
    set_modulus(WIDTH'(0));
    send_request(16'd5, 16'd0);
    send_request(16'd5, 16'd7);
    send_request(16'hffff, 16'hffff);
  endtask

  task automatic test_random_phases();
    logic [WIDTH-1:0] m;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       m = WIDTH'(2);
        1:       m = WIDTH'(MOD_MAX);
        2:       m = WIDTH'($urandom_range(3, 300));
        default: m = WIDTH'($urandom_range(2, MOD_MAX));
      endcase
      set_modulus(m);
      for (int i = 0; i < PHASE_REQUESTS; i++) send_random_request();
    end
  endtask

  // long receiver hold-off so the block fills up and stalls its input
  task automatic test_backpressure();
    set_modulus(WIDTH'($urandom_range(1000, MOD_MAX)));
    hold_cycles = HOLD_OFF;
    burst_left  = 12;
    for (int i = 0; i < 12; i++) send_random_request();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_modulus();
    test_modulus_extremes();
    test_degenerate_modulus();
    test_backpressure();
    test_random_phases();
    s_tvalid <= 1'b0;
    while (expected_power_mod.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d requests sent, %0d results checked, %0d modulus writes, %0d mismatches",
             requests_sent, results_checked, moduli_written, error_count);
    $display("covered zero exponents, moduli 0, 1, 2 and 65535, reduced bases and a long hold-off");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== modular_exponentiation.f =====
+incdir+design
design/mexp_pkg.sv
design/mexp_dp.sv
design/mexp_ctrl.sv
design/modular_exponentiation.sv
tb/sv/tb_modular_exponentiation.sv
